// ----- rtl/wspm_pkg.sv -----
// Package for the wildcard star pattern matcher: shared constants, codes and types.
// Used by every module in the rtl folder; it depends on nothing else.
package wspm_pkg;

   localparam int MaxPattern = 16;
   localparam int ByteWidth  = 8;
   localparam int LenWidth   = 5;
   localparam int SetWidth   = MaxPattern + 1;
   localparam int CsrWidth   = 64;
   localparam int CsrIdxWidth = 2;

   localparam logic [ByteWidth-1:0] StarByte = 8'h2A;
   localparam logic [ByteWidth-1:0] DotByte  = 8'h2E;

   // Live set holding only the pattern start position, before closure.
   localparam logic [SetWidth-1:0] RestartSet = SetWidth'(1);

   typedef enum logic {
      ActText = 1'b0,
      ActEnd  = 1'b1
   } wspm_action_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CsrPatLow  = 2'd0,
      CsrPatHigh = 2'd1,
      CsrPatLen  = 2'd2
   } wspm_csr_type;

   // Decoded pattern handed from the register file to the matching engine.
   typedef struct packed {
      logic [MaxPattern-1:0][ByteWidth-1:0] bytes;
      logic [MaxPattern-1:0]                star;
      logic [MaxPattern-1:0]                in_use;
      logic [LenWidth-1:0]                  len;
   } wspm_cfg_type;

endpackage

// ----- rtl/wildcard_star_pattern_matcher_top.sv -----
// Top level of the wildcard star pattern matcher: input register, engine and result register.
// Depends on wspm_pkg, wspm_config and wspm_engine.
//
// An accepted end-of-text transaction enters the input register and is offered on rsp once
// it has moved on into the result register, after one pass through the engine.
// Throughput: one transaction per cycle. A result waiting under rsp_stall holds a following
// end-of-text transaction in the input register, and while it is held every new transaction
// sees req_stall; a text byte in the input register never waits.
// Reset (synchronous, active high) clears the pattern registers and the valid flags and
// leaves the live set at the pattern start position.
module wildcard_star_pattern_matcher_top (
   input  logic                              clock,
   input  logic                              reset,
   // Text byte and end-of-text transactions.
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_action,
   input  logic [wspm_pkg::ByteWidth-1:0]    req_text_byte,
   // Match results, one for each end-of-text transaction.
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_matched,
   // Pattern register writes.
   input  logic                              csr_write_enable,
   input  logic [wspm_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [wspm_pkg::CsrWidth-1:0]     csr_wdata
);

   logic                           in_valid_ff, in_valid_in;
   logic                           in_action_ff, in_action_in;
   logic [wspm_pkg::ByteWidth-1:0] in_byte_ff, in_byte_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_matched_ff, rsp_matched_in;

   wspm_pkg::wspm_cfg_type cfg;
   logic                   cfg_restart;
   logic                   engine_matched;
   logic                   end_item;
   logic                   out_free;
   logic                   advance;
   logic                   req_accept;

   wspm_config u_config (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cfg              (cfg),
      .cfg_restart      (cfg_restart)
   );

   // The held transaction is worked on by the engine in the cycle it leaves the input
   // register. A text byte always leaves at once; an end of text needs room in the
   // result register, which is free when empty or when its result is being taken.
   assign end_item  = (wspm_pkg::wspm_action_type'(in_action_ff) == wspm_pkg::ActEnd);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!end_item || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   wspm_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .fire        (advance),
      .action      (in_action_ff),
      .text_byte   (in_byte_ff),
      .cfg         (cfg),
      .cfg_restart (cfg_restart),
      .matched     (engine_matched)
   );

   // Input register: reloads whenever the held transaction moves on or the stage is empty.
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_action_in = in_action_ff;
      in_byte_in   = in_byte_ff;
      if (req_accept) begin
         in_valid_in  = 1'b1;
         in_action_in = req_action;
         in_byte_in   = req_text_byte;
      end else if (advance) begin
         in_valid_in  = 1'b0;
      end
   end

   // Result register: filled by an end of text, emptied when the consumer takes it.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_matched_in = rsp_matched_ff;
      if (advance && end_item) begin
         rsp_valid_in   = 1'b1;
         rsp_matched_in = engine_matched;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_action_ff   <= in_action_in;
      in_byte_ff     <= in_byte_in;
      rsp_matched_ff <= rsp_matched_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_matched = rsp_matched_ff;

   // A result only ever appears after an end-of-text transaction left the input register.
   a_rsp_from_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance && end_item))
      else $error("result raised without an end-of-text transaction");

   // Back-pressure on the request side comes only from a stalled, occupied result register.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && end_item && rsp_valid_ff && rsp_stall))
      else $error("request stalled without a blocked result");

   // A text byte passing through never disturbs a waiting result.
   a_text_keeps_rsp: assert property (@(posedge clock) disable iff (reset)
      (advance && !end_item && rsp_valid_ff && rsp_stall) |=>
      (rsp_valid_ff && $stable(rsp_matched_ff)))
      else $error("waiting result disturbed by a text byte");

endmodule

// ----- rtl/wspm_config.sv -----
// Register file for the pattern bytes and length, with pattern decoding.
// Depends on wspm_pkg.
module wspm_config (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [wspm_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [wspm_pkg::CsrWidth-1:0]        csr_wdata,
   output wspm_pkg::wspm_cfg_type               cfg,
   output logic                                 cfg_restart
);

   logic [wspm_pkg::CsrWidth-1:0] pat_low_ff, pat_low_in;
   logic [wspm_pkg::CsrWidth-1:0] pat_high_ff, pat_high_in;
   logic [wspm_pkg::LenWidth-1:0] pat_len_ff, pat_len_in;
   logic [wspm_pkg::LenWidth-1:0] eff_len;
   logic [2*wspm_pkg::CsrWidth-1:0] all_bytes;

   always_comb begin
      pat_low_in  = pat_low_ff;
      pat_high_in = pat_high_ff;
      pat_len_in  = pat_len_ff;
      cfg_restart = 1'b0;
      if (csr_write_enable) begin
         case (wspm_pkg::wspm_csr_type'(csr_index))
            wspm_pkg::CsrPatLow: begin
               pat_low_in  = csr_wdata;
               cfg_restart = 1'b1;
            end
            wspm_pkg::CsrPatHigh: begin
               pat_high_in = csr_wdata;
               cfg_restart = 1'b1;
            end
            wspm_pkg::CsrPatLen: begin
               pat_len_in  = csr_wdata[wspm_pkg::LenWidth-1:0];
               cfg_restart = 1'b1;
            end
            default: begin
               cfg_restart = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         pat_len_ff  <= '0;
      end else begin
         pat_low_ff  <= pat_low_in;
         pat_high_ff <= pat_high_in;
         pat_len_ff  <= pat_len_in;
      end
   end

   // A length beyond the pattern store is taken as the full store.
   assign eff_len = (pat_len_ff > wspm_pkg::LenWidth'(wspm_pkg::MaxPattern)) ?
                    wspm_pkg::LenWidth'(wspm_pkg::MaxPattern) : pat_len_ff;
   assign all_bytes = {pat_high_ff, pat_low_ff};

   always_comb begin
      cfg.len = eff_len;
      for (int i = 0; i < wspm_pkg::MaxPattern; i++) begin
         cfg.bytes[i]  = all_bytes[i*wspm_pkg::ByteWidth +: wspm_pkg::ByteWidth];
         cfg.in_use[i] = wspm_pkg::LenWidth'(i) < eff_len;
      end
      // An element followed by a star inside the used length may repeat or be skipped.
      for (int i = 0; i < wspm_pkg::MaxPattern - 1; i++) begin
         cfg.star[i] = (wspm_pkg::LenWidth'(i + 1) < eff_len) &&
                       (all_bytes[(i+1)*wspm_pkg::ByteWidth +: wspm_pkg::ByteWidth] ==
                        wspm_pkg::StarByte);
      end
      cfg.star[wspm_pkg::MaxPattern-1] = 1'b0;
   end

endmodule

// ----- rtl/wspm_engine.sv -----
// Live position set of the pattern automaton: byte step, star-skip closure and restart.
// Depends on wspm_pkg and the decoded pattern from wspm_config.
module wspm_engine (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              fire,
   input  logic                              action,
   input  logic [wspm_pkg::ByteWidth-1:0]    text_byte,
   input  wspm_pkg::wspm_cfg_type            cfg,
   input  logic                              cfg_restart,
   output logic                              matched
);

   // The register holds the set before closure; closure is applied on every read.
   logic [wspm_pkg::SetWidth-1:0] raw_ff, raw_in;
   logic [wspm_pkg::SetWidth-1:0] live;
   logic [wspm_pkg::SetWidth-1:0] stepped;
   logic [wspm_pkg::SetWidth-1:0] reach_mask;
   logic                          is_end;

   assign is_end = (wspm_pkg::wspm_action_type'(action) == wspm_pkg::ActEnd);

   always_comb begin
      live = raw_ff;
      for (int i = 0; i < wspm_pkg::MaxPattern - 1; i++) begin
         live[i+2] = live[i+2] | (live[i] & cfg.star[i]);
      end
   end

   always_comb begin
      stepped = '0;
      for (int i = 0; i < wspm_pkg::MaxPattern; i++) begin
         if (live[i] && cfg.in_use[i] &&
             ((cfg.bytes[i] == wspm_pkg::DotByte) || (cfg.bytes[i] == text_byte))) begin
            if (cfg.star[i]) begin
               stepped[i] = 1'b1;
            end else begin
               stepped[i+1] = 1'b1;
            end
         end
      end
   end

   assign matched = live[cfg.len];

   always_comb begin
      raw_in = raw_ff;
      if (cfg_restart || (fire && is_end)) begin
         raw_in = wspm_pkg::RestartSet;
      end else if (fire) begin
         raw_in = stepped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff <= wspm_pkg::RestartSet;
      end else begin
         raw_ff <= raw_in;
      end
   end

   always_comb begin
      for (int i = 0; i < wspm_pkg::SetWidth; i++) begin
         reach_mask[i] = wspm_pkg::LenWidth'(i) <= cfg.len;
      end
   end

   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      (fire && is_end) |=> (raw_ff == wspm_pkg::RestartSet))
      else $error("live set not restarted after end of text");

   a_cfg_restarts: assert property (@(posedge clock) disable iff (reset)
      cfg_restart |=> (raw_ff == wspm_pkg::RestartSet))
      else $error("live set not restarted after a register write");

   a_within_len: assert property (@(posedge clock) disable iff (reset)
      ((raw_ff & ~reach_mask) == '0))
      else $error("live position beyond the pattern end");

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the wildcard star pattern matcher. It streams text transactions,
// predicts every match result with its own position-set automaton, and checks each result.
// Depends on wspm_pkg and wildcard_star_pattern_matcher_top from the rtl folder.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import wspm_pkg::*;

   typedef logic [MaxPattern-1:0][ByteWidth-1:0] pattern_image_type;

   // Every input of the block starts from a known value; reset is held from time zero.
   logic                    clock            = 1'b0;
   logic                    reset            = 1'b1;
   logic                    req_valid        = 1'b0;
   logic                    req_stall;
   logic                    req_action       = 1'b0;
   logic [ByteWidth-1:0]    req_text_byte    = '0;
   logic                    rsp_valid;
   logic                    rsp_stall        = 1'b0;
   logic                    rsp_matched;
   logic                    csr_write_enable = 1'b0;
   logic [CsrIdxWidth-1:0]  csr_index        = '0;
   logic [CsrWidth-1:0]     csr_wdata        = '0;

   // Our own copy of the pattern registers and of the live position set.
   logic [CsrWidth-1:0]     pattern_low_copy;
   logic [CsrWidth-1:0]     pattern_high_copy;
   logic [LenWidth-1:0]     pattern_len_copy;
   logic [SetWidth-1:0]     live_set;

   // Match bits still owed by the block, oldest first.
   logic                    expected_matches[$];
   // Text of the next string to be streamed in.
   logic [ByteWidth-1:0]    pending_text[$];

   int                      items_sent  = 0;
   int                      error_count = 0;
   // When cleared, neither the sender nor the result side inserts any idle cycles.
   bit                      idling_on   = 1'b1;
   int                      stall_left  = 0;

   wildcard_star_pattern_matcher_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_text_byte    (req_text_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_matched      (rsp_matched),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // 12 ns clock period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------------------

   // A length beyond the largest pattern is clamped to the largest pattern.
   function automatic int used_length();
      return (pattern_len_copy > MaxPattern) ? MaxPattern : int'(pattern_len_copy);
   endfunction

   function automatic logic [ByteWidth-1:0] pattern_char(int pos);
      if (pos < 8) return pattern_low_copy[8*pos +: 8];
      if (pos < 16) return pattern_high_copy[8*(pos-8) +: 8];
      return '0;
   endfunction

   // A position is a repeating element when the byte after it, still inside the pattern,
   // is a star. Any other star, leading or doubled, is an ordinary literal byte.
   function automatic bit repeats(int pos, int n);
      return (pos + 1 < n) && (pattern_char(pos + 1) == StarByte);
   endfunction

   // Closes a position set over the skips that a repeating element allows. Walking upwards
   // lets chains of consecutive skips propagate in a single pass.
   function automatic logic [SetWidth-1:0] skip_closure(logic [SetWidth-1:0] s);
      int n = used_length();
      for (int pos = 0; pos <= n; pos++) begin
         if (s[pos] && repeats(pos, n)) s[pos+2] = 1'b1;
      end
      return s;
   endfunction

   function automatic void consume_byte(logic [ByteWidth-1:0] c);
      int n = used_length();
      logic [SetWidth-1:0] nxt = '0;
      logic [ByteWidth-1:0] pc;
      for (int pos = 0; pos < n; pos++) begin
         if (live_set[pos]) begin
            pc = pattern_char(pos);
            if (pc == DotByte || pc == c) begin
               if (repeats(pos, n)) nxt[pos] = 1'b1;
               else nxt[pos+1] = 1'b1;
            end
         end
      end
      live_set = skip_closure(nxt);
   endfunction

   // Called at the clock edge that accepts a transaction on the input channel.
   function automatic void predict_transaction(wspm_action_type act, logic [ByteWidth-1:0] c);
      if (act == ActEnd) begin
         expected_matches.push_back(live_set[used_length()]);
         live_set = skip_closure(RestartSet);
      end else begin
         consume_byte(c);
      end
   endfunction

   // ---------------------------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= 40) $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   // Outputs are read in the active region of the edge, so they still hold the values that
   // the edge itself samples.
   always @(posedge clock) begin
      logic want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_matches.size() == 0) begin
            report_mismatch($sformatf("result transaction (matched=%0b) with none pending",
                                      rsp_matched));
         end else begin
            want = expected_matches.pop_front();
            if (rsp_matched !== want)
               report_mismatch($sformatf("matched is %0b, predicted %0b", rsp_matched, want));
         end
      end
   end

   // The result side holds off in bursts of random length.
   always @(posedge clock) begin
      if (stall_left == 0 && idling_on && $urandom_range(0, 4) == 0)
         stall_left = $urandom_range(1, 10);
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------------------------------

   // Offers one transaction and returns at the edge that accepts it. The valid is only
   // lowered for an idle burst, so back-to-back transactions keep it high throughout.
   task automatic send_item(input wspm_action_type act, input logic [ByteWidth-1:0] c);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= act;
      req_text_byte <= c;
      do @(posedge clock); while (req_stall);
      predict_transaction(act, c);
      items_sent++;
   endtask

   // Streams the pending text followed by an end-of-text transaction.
   task automatic send_text();
      foreach (pending_text[j]) send_item(ActText, pending_text[j]);
      send_item(ActEnd, ByteWidth'($urandom));
   endtask

   task automatic send_string(input string s);
      pending_text = {};
      for (int j = 0; j < s.len(); j++) pending_text.push_back(s[j]);
      send_text();
   endtask

   // Waits until every result has come back. Text bytes give no result, so an extra wait
   // after that lets the last of them clear the two-stage pipeline.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_matches.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Drives one register write for the next edge. The enable is left high so that writes
   // can follow back to back; the caller lowers it after the last one.
   task automatic write_register(input wspm_csr_type idx, input logic [CsrWidth-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= data;
      @(posedge clock);
      case (idx)
         CsrPatLow:  pattern_low_copy  = data;
         CsrPatHigh: pattern_high_copy = data;
         CsrPatLen:  pattern_len_copy  = data[LenWidth-1:0];
         default: ;
      endcase
      // Any write starts matching afresh under the new pattern.
      live_set = skip_closure(RestartSet);
   endtask

   task automatic program_pattern(input pattern_image_type image, input int len);
      wait_idle();
      write_register(CsrPatLow, image[7:0]);
      write_register(CsrPatHigh, image[15:8]);
      write_register(CsrPatLen, CsrWidth'(len));
      csr_write_enable <= 1'b0;
   endtask

   function automatic pattern_image_type pattern_from(string s);
      pattern_image_type image = '0;
      for (int j = 0; j < s.len() && j < MaxPattern; j++) image[j] = s[j];
      return image;
   endfunction

   // Mostly bytes that patterns are built from, so that matches are common.
   function automatic logic [ByteWidth-1:0] any_byte();
      case ($urandom_range(0, 6))
         0: return "a";
         1: return "b";
         2: return "c";
         3: return StarByte;
         4: return DotByte;
         default: return ByteWidth'($urandom);
      endcase
   endfunction

   function automatic logic [ByteWidth-1:0] random_pattern_char();
      int r = $urandom_range(0, 19);
      if (r < 5) return StarByte;
      if (r < 8) return DotByte;
      if (r < 13) return "a";
      if (r < 17) return "b";
      if (r < 18) return "c";
      return ByteWidth'($urandom);
   endfunction

   // Builds the next text. Most texts are walked out of the current pattern so that they
   // match, some of them then spoiled by one byte; the rest are noise.
   task automatic make_text();
      int n, pos, r;
      logic [ByteWidth-1:0] pc;
      pending_text = {};
      n = used_length();
      r = $urandom_range(0, 9);
      if (r < 7) begin
         pos = 0;
         while (pos < n) begin
            pc = pattern_char(pos);
            if (repeats(pos, n)) begin
               // One walk in seven uses long runs, to show the text length is unbounded.
               repeat ((r == 6) ? $urandom_range(0, 25) : $urandom_range(0, 3))
                  pending_text.push_back(pc == DotByte ? any_byte() : pc);
               pos += 2;
            end else begin
               pending_text.push_back(pc == DotByte ? any_byte() : pc);
               pos++;
            end
         end
         if (r == 4 && pending_text.size() > 0)
            pending_text[$urandom_range(0, pending_text.size() - 1)] = any_byte();
         else if (r == 5 && pending_text.size() > 0 && $urandom_range(0, 1) == 0)
            void'(pending_text.pop_back());
         else if (r == 5)
            pending_text.push_back(any_byte());
      end else if (r < 9) begin
         repeat ($urandom_range(0, 10)) pending_text.push_back(any_byte());
      end else begin
         repeat ($urandom_range(0, 6)) pending_text.push_back(ByteWidth'($urandom));
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   // Straight after reset the pattern is empty, so only the empty text matches.
   task automatic test_after_reset();
      send_item(ActEnd, 8'h00);
      send_item(ActText, 8'hFF);
      send_item(ActEnd, 8'hFF);
   endtask

   // A dot under a star swallows anything, the extreme byte values and a star included.
   task automatic test_dot_star();
      program_pattern(pattern_from(".*"), 2);
      send_item(ActText, 8'h00);
      send_item(ActText, 8'hFF);
      send_item(ActText, StarByte);
      send_item(ActEnd, 8'h00);
   endtask

   // A leading star and the second star of a pair are literal bytes.
   task automatic test_literal_stars();
      program_pattern(pattern_from("*a**"), 4);
      send_string("*aa*");
   endtask

   // A full sixteen-byte pattern with the largest length code, which is clamped to sixteen.
   task automatic test_overlong_length();
      program_pattern(pattern_from("x*x*x*x*x*x*x*x*"), 31);
      send_string("");
      send_string("xx");
      send_string("y");
   endtask

   // A register write in the middle of a text throws the partial match away.
   task automatic test_write_restarts();
      program_pattern(pattern_from("ab"), 2);
      send_item(ActText, "a");
      wait_idle();
      write_register(CsrPatLen, CsrWidth'(2));
      csr_write_enable <= 1'b0;
      send_item(ActText, "b");
      send_item(ActEnd, 8'h00);
   endtask

   // Phases of random patterns, each followed by a handful of texts, until the running
   // count of transactions reaches the target.
   task automatic test_random_patterns(input int target, input bit with_idling);
      pattern_image_type image;
      int len, r;
      idling_on = with_idling;
      while (items_sent < target) begin
         wait_idle();
         r = $urandom_range(0, 19);
         for (int j = 0; j < MaxPattern; j++)
            image[j] = (r == 0) ? 8'hFF : (r == 1) ? 8'h00 : random_pattern_char();
         r = $urandom_range(0, 15);
         if (r == 0) len = MaxPattern;
         else if (r == 1) len = $urandom_range(MaxPattern + 1, 31);
         else if (r == 2) len = 0;
         else len = $urandom_range(1, MaxPattern);
         // Now and then only one register changes, keeping the others from before.
         case ($urandom_range(0, 7))
            0: write_register(CsrPatLen, CsrWidth'(len));
            1: write_register(CsrPatLow, image[7:0]);
            2: write_register(CsrPatHigh, image[15:8]);
            3: begin
               write_register(CsrPatLen, CsrWidth'(len));
               write_register(CsrPatHigh, image[15:8]);
               write_register(CsrPatLow, image[7:0]);
            end
            default: begin
               write_register(CsrPatLow, image[7:0]);
               write_register(CsrPatHigh, image[15:8]);
               write_register(CsrPatLen, CsrWidth'(len));
            end
         endcase
         csr_write_enable <= 1'b0;
         repeat ($urandom_range(2, 8)) begin
            make_text();
            send_text();
         end
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------------------

   initial begin
      pattern_low_copy  = '0;
      pattern_high_copy = '0;
      pattern_len_copy  = '0;
      live_set          = skip_closure(RestartSet);
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_after_reset();
      test_dot_star();
      test_literal_stars();
      test_overlong_length();
      test_write_restarts();
      test_random_patterns(1200, 1'b1);
      // The closing stretch runs flat out on both channels.
      test_random_patterns(1350, 1'b0);

      req_valid <= 1'b0;
      while (expected_matches.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Safety net far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
